// ===== hdl/mac_learning_forward_table_defines.svh =====
// Assertion macros shared by the project.
`ifndef MAC_LEARNING_FORWARD_TABLE_DEFINES_SVH
`define MAC_LEARNING_FORWARD_TABLE_DEFINES_SVH

// Same-cycle implication.
`define MLFT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MLFT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mlft_pkg.sv =====
`timescale 1ns / 1ps
package mlft_pkg;

   localparam int NUM_PORTS_DEF   = 8;
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int MAC_W           = 48;
   localparam int PORT_W          = 3;
   localparam int MASK_W          = 8;
   localparam int CSR_W           = 4;
   localparam logic [CSR_W-1:0] CSR_PORTS_RESET = CSR_W'(8);

   typedef struct packed {
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [PORT_W-1:0] in_port;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] port_mask;
      logic              dst_found;
      logic              learned;
      logic              learn_dropped;
   } rsp_type;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } entry_type;

   function automatic logic [MASK_W-1:0] port_onehot(input logic [PORT_W-1:0] port);
      logic [MASK_W-1:0] m;
      m = '0;
      m[port] = 1'b1;
      return m;
   endfunction

   function automatic logic [MASK_W-1:0] flood_mask(input logic [CSR_W-1:0] n,
                                                    input logic [PORT_W-1:0] in_port);
      logic [MASK_W-1:0] m;
      m = '0;
      for (int p = 0; p < MASK_W; p++) begin
         if ((CSR_W'(p) < n) && (PORT_W'(p) != in_port)) begin
            m[p] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

// ===== hdl/mlft_ram.sv =====
`timescale 1ns / 1ps
module mlft_ram #(
   parameter int TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  mlft_pkg::entry_type            wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output mlft_pkg::entry_type            rd_data
);
   import mlft_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mlft_engine.sv =====
`timescale 1ns / 1ps
module mlft_engine #(
   parameter int NUM_PORTS   = mlft_pkg::NUM_PORTS_DEF,
   parameter int TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  mlft_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output mlft_pkg::rsp_type              rsp_data,
   input  logic [mlft_pkg::CSR_W-1:0]     ports_in_use,
   output logic                           ram_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] ram_rd_addr,
   input  mlft_pkg::entry_type            ram_rd_data,
   output logic                           ram_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] ram_wr_addr,
   output mlft_pkg::entry_type            ram_wr_data
);
   import mlft_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0]    DEPTH_C = CW'(TABLE_DEPTH);
   localparam logic [CSR_W-1:0] NP_C    = CSR_W'(NUM_PORTS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CW-1:0]     iss_ff, iss_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              chk_ff, chk_in;
   logic              src_hit_ff, src_hit_in;
   logic              dst_hit_ff, dst_hit_in;
   logic [PORT_W-1:0] dst_port_ff, dst_port_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              learn;
   logic [CSR_W-1:0]  flood_n;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      iss_in       = iss_ff;
      count_in     = count_ff;
      chk_in       = chk_ff;
      src_hit_in   = src_hit_ff;
      dst_hit_in   = dst_hit_ff;
      dst_port_in  = dst_port_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      learn        = !src_hit_ff && (count_ff < DEPTH_C);
      flood_n      = (ports_in_use > NP_C) ? NP_C : ports_in_use;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in     = req_data;
               iss_in     = '0;
               chk_in     = 1'b0;
               src_hit_in = 1'b0;
               dst_hit_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (chk_ff) begin
               if (ram_rd_data.mac == req_ff.src_mac) begin
                  src_hit_in = 1'b1;
               end
               if (ram_rd_data.mac == req_ff.dst_mac) begin
                  dst_hit_in  = 1'b1;
                  dst_port_in = ram_rd_data.port;
               end
            end
            if (iss_ff != count_ff) begin
               ram_rd_en = 1'b1;
               iss_in    = iss_ff + CW'(1);
               chk_in    = 1'b1;
            end else begin
               chk_in   = 1'b0;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ram_wr_en            = learn;
            count_in             = learn ? count_ff + CW'(1) : count_ff;
            rsp_in.learned       = learn;
            rsp_in.learn_dropped = !src_hit_ff && !learn;
            if (dst_hit_ff) begin
               rsp_in.dst_found = 1'b1;
               rsp_in.port_mask = port_onehot(dst_port_ff);
            end else if (learn && (req_ff.dst_mac == req_ff.src_mac)) begin
               rsp_in.dst_found = 1'b1;
               rsp_in.port_mask = port_onehot(req_ff.in_port);
            end else begin
               rsp_in.dst_found = 1'b0;
               rsp_in.port_mask = flood_mask(flood_n, req_ff.in_port);
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      iss_ff      <= iss_in;
      chk_ff      <= chk_in;
      src_hit_ff  <= src_hit_in;
      dst_hit_ff  <= dst_hit_in;
      dst_port_ff <= dst_port_in;
      rsp_ff      <= rsp_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign ram_rd_addr      = iss_ff[AW-1:0];
   assign ram_wr_addr      = count_ff[AW-1:0];
   assign ram_wr_data.mac  = req_ff.src_mac;
   assign ram_wr_data.port = req_ff.in_port;

endmodule

// ===== hdl/mac_learning_forward_table.sv =====
`timescale 1ns / 1ps
// MAC learning and forwarding decision for a small Ethernet switch.
// Request channel: drive req_data (source MAC, destination MAC, ingress port)
// and raise start; the request is taken at a clock edge with start high and
// busy low. Busy stays high while the request is processed.
// Response channel: rsp_valid pulses for one cycle with rsp_data holding the
// port mask, destination hit, learned and learn-dropped flags. The receiver
// cannot stall; the response must be taken in that cycle.
// Timing: the table is scanned one entry per cycle through a synchronous RAM
// with separate read and write ports; only the stored entries are scanned, at
// most TABLE_DEPTH. The response is shown in the cycle busy drops, and a new
// request may be taken in the cycle the response is shown, so one request
// must finish before the next is accepted.
// Configuration: csr_write_data is written to the ports-in-use register at an
// edge with csr_write_en high; write only while idle.
// Reset (synchronous, active high): table emptied through its fill count, no
// clearing pass; ports in use returns to 8; no response pending.
module mac_learning_forward_table #(
   parameter int NUM_PORTS   = mlft_pkg::NUM_PORTS_DEF,
   parameter int TABLE_DEPTH = mlft_pkg::TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  mlft_pkg::req_type          req_data,
   output logic                       rsp_valid,
   output mlft_pkg::rsp_type          rsp_data,
   input  logic                       csr_write_en,
   input  logic [mlft_pkg::CSR_W-1:0] csr_write_data
);
   import mlft_pkg::*;
   `include "mac_learning_forward_table_defines.svh"

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [CSR_W-1:0] ports_in_use_ff, ports_in_use_in;
   logic             ram_rd_en, ram_wr_en;
   logic [AW-1:0]    ram_rd_addr, ram_wr_addr;
   entry_type        ram_rd_data, ram_wr_data;

   assign ports_in_use_in = csr_write_en ? csr_write_data : ports_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_in_use_ff <= CSR_PORTS_RESET;
      end else begin
         ports_in_use_ff <= ports_in_use_in;
      end
   end

   mlft_engine #(
      .NUM_PORTS   (NUM_PORTS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .ports_in_use (ports_in_use_ff),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data)
   );

   mlft_ram #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   `MLFT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted request not busy")
   `MLFT_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy, "response while busy")
   `MLFT_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "response repeated")
   `MLFT_ASSERT_IMP(a_hit_onehot, clock, reset, rsp_valid && rsp_data.dst_found, $onehot(rsp_data.port_mask) && !(rsp_data.learned && rsp_data.learn_dropped), "bad hit response")

endmodule

// ===== sim/mac_learning_forward_table_checker.sv =====
`timescale 1ns / 1ps
module mac_learning_forward_table_checker
   import mlft_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  rsp_type          rsp_data,
   input  logic             csr_write_en,
   input  logic [CSR_W-1:0] csr_write_data,
   output int               fail_count,
   output int               pending_count,
   output int               request_count,
   output int               hit_count,
   output int               flood_count,
   output int               learn_count,
   output int               drop_count
);

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int PORTS = NUM_PORTS_DEF;

   logic [MAC_W-1:0]  known_mac [DEPTH];
   logic [PORT_W-1:0] known_port [DEPTH];
   bit                known_valid [DEPTH];
   int                known_count = 0;
   logic [CSR_W-1:0]  active_ports = CSR_PORTS_RESET;
   rsp_type           expected_decisions [$];
   int                errors = 0;
   int                requests = 0;
   int                hits = 0;
   int                floods = 0;
   int                learns = 0;
   int                drops = 0;

   function automatic int find_mac(input logic [MAC_W-1:0] mac);
      for (int k = 0; k < DEPTH; k++) begin
         if (known_valid[k] && known_mac[k] == mac) begin
            return k;
         end
      end
      return -1;
   endfunction

   // learn first, then look up the destination
   task automatic forward_decision(input req_type r, output rsp_type d);
      int slot;
      int limit;
      d = '0;
      if (find_mac(r.src_mac) < 0) begin
         if (known_count < DEPTH) begin
            known_mac[known_count]   = r.src_mac;
            known_port[known_count]  = r.in_port;
            known_valid[known_count] = 1'b1;
            known_count++;
            d.learned = 1'b1;
         end else begin
            d.learn_dropped = 1'b1;
         end
      end
      slot = find_mac(r.dst_mac);
      if (slot >= 0) begin
         d.dst_found = 1'b1;
         d.port_mask = MASK_W'(1) << known_port[slot];
      end else begin
         limit = (int'(active_ports) > PORTS) ? PORTS : int'(active_ports);
         for (int p = 0; p < limit && p < MASK_W; p++) begin
            if (p != int'(r.in_port)) begin
               d.port_mask[p] = 1'b1;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      logic    bad;
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) begin
            known_valid[k] = 1'b0;
         end
         known_count  = 0;
         active_ports = CSR_PORTS_RESET;
         expected_decisions.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_decisions.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: unexpected response mask %02h found %b learned %b dropped %b",
                           $time, rsp_data.port_mask, rsp_data.dst_found,
                           rsp_data.learned, rsp_data.learn_dropped);
               end
            end else begin
               want = expected_decisions.pop_front();
               bad  = (rsp_data.port_mask !== want.port_mask) ||
                      (rsp_data.dst_found !== want.dst_found) ||
                      (rsp_data.learned !== want.learned) ||
                      (rsp_data.learn_dropped !== want.learn_dropped);
               if (bad) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: mismatch expected mask %02h found %b learned %b dropped %b",
                              $time, want.port_mask, want.dst_found, want.learned,
                              want.learn_dropped);
                     $display("         actual   mask %02h found %b learned %b dropped %b",
                              rsp_data.port_mask, rsp_data.dst_found, rsp_data.learned,
                              rsp_data.learn_dropped);
                  end
               end
            end
         end
         if (csr_write_en) begin
            active_ports = csr_write_data;
         end
         if (start && !busy) begin
            forward_decision(req_data, want);
            expected_decisions.push_back(want);
            requests++;
            if (want.dst_found) begin
               hits++;
            end else begin
               floods++;
            end
            if (want.learned) begin
               learns++;
            end
            if (want.learn_dropped) begin
               drops++;
            end
         end
      end
      fail_count    <= errors;
      pending_count <= expected_decisions.size();
      request_count <= requests;
      hit_count     <= hits;
      flood_count   <= floods;
      learn_count   <= learns;
      drop_count    <= drops;
   end

endmodule

// ===== sim/mac_learning_forward_table_tb.sv =====
`timescale 1ns / 1ps
module mac_learning_forward_table_tb;
   import mlft_pkg::*;

   localparam int RANDOM_REQUESTS = 930;
   localparam int PHASES          = 10;
   localparam int POOL_SIZE       = 80;
   localparam int IDLE_LIMIT      = 2000;
   localparam int SETTLE_CYCLES   = 80;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_write_en;
   logic [CSR_W-1:0] csr_write_data;

   int fail_count;
   int pending_count;
   int request_count;
   int hit_count;
   int flood_count;
   int learn_count;
   int drop_count;
   int idle_cycles = 0;

   logic [MAC_W-1:0] mac_pool [POOL_SIZE];

   mac_learning_forward_table uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   mac_learning_forward_table_checker decision_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .request_count  (request_count),
      .hit_count      (hit_count),
      .flood_count    (flood_count),
      .learn_count    (learn_count),
      .drop_count     (drop_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no request or response for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [MAC_W-1:0] random_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   task automatic send_request(input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst,
                               input logic [PORT_W-1:0] port, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= req_type'{src, dst, port};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_all();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0 || busy);
   endtask

   task automatic write_ports(input logic [CSR_W-1:0] value);
      drain_all();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      logic [MAC_W-1:0] src;
      logic [MAC_W-1:0] dst;
      logic [MAC_W-1:0] mac_a;
      logic [MAC_W-1:0] mac_b;
      logic [CSR_W-1:0] phase_ports [PHASES];
      int               pick;
      int               gap;
      bit               burst;

      reset          <= 1'b1;
      start          <= 1'b0;
      req_data       <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      phase_ports = '{4'd8, 4'd2, 4'd15, 4'd0, 4'd1, 4'd5, 4'd8, 4'd3, 4'd9, 4'd8};
      for (int k = 0; k < POOL_SIZE; k++) begin
         mac_pool[k] = random_mac();
      end
      mac_a = random_mac();
      mac_b = random_mac();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // all-zero and all-one MACs, dst == src, hit on ingress, known source
      send_request('0, '1, 3'd0, 0);
      send_request('1, '0, 3'd7, 0);
      send_request(mac_a, mac_a, 3'd3, $urandom_range(0, 19));
      send_request('0, '1, 3'd5, 0);
      send_request(mac_b, mac_a, 3'd3, 0);
      send_request(random_mac(), random_mac(), 3'd7, 0);

      // flood width: small count, ingress beyond count, saturation, zero, one
      write_ports(4'd2);
      send_request(random_mac(), random_mac(), 3'd0, 0);
      send_request(random_mac(), random_mac(), 3'd1, 0);
      send_request(random_mac(), random_mac(), 3'd6, 0);
      write_ports(4'd15);
      send_request(random_mac(), random_mac(), 3'd4, 0);
      write_ports(4'd0);
      send_request(random_mac(), random_mac(), 3'd2, 0);
      write_ports(4'd1);
      send_request(random_mac(), random_mac(), 3'd0, 0);
      send_request(random_mac(), random_mac(), 3'd5, 0);

      // pool sources fill the table, then new ones get dropped
      for (int ph = 0; ph < PHASES; ph++) begin
         write_ports(phase_ports[ph]);
         burst = (ph % 3 == 1);
         for (int i = 0; i < RANDOM_REQUESTS / PHASES; i++) begin
            if (ph == 4 && i == 40) begin
               drain_all();
            end
            pick = $urandom_range(0, 99);
            src  = (pick < 8) ? random_mac() : mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               dst = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (pick < 75) begin
               dst = src;
            end else begin
               dst = random_mac();
            end
            gap = burst ? 0 : $urandom_range(0, 19);
            send_request(src, dst, PORT_W'($urandom_range(0, 7)), gap);
         end
      end

      drain_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d requests: %0d destination hits, %0d floods",
               request_count, hit_count, flood_count);
      $display("sources learned %0d, dropped on full table %0d, port counts 0 to 15",
               learn_count, drop_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== mac_learning_forward_table.f =====
+incdir+hdl
hdl/mlft_pkg.sv
hdl/mlft_ram.sv
hdl/mlft_engine.sv
hdl/mac_learning_forward_table.sv
sim/mac_learning_forward_table_checker.sv
sim/mac_learning_forward_table_tb.sv
